/* hw/rtl/mpf_pkg.sv */
// Shared constants, command codes and state type for the page framebuffer.
package mpf_pkg;

  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int CHUNK_BYTES = 16;

  localparam int ROWS        = PAGES * 8;
  localparam int FRAME_BYTES = COLUMNS * PAGES;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int COLX_W      = $clog2(8 * CHUNK_BYTES);

  localparam int CMD_W    = 3;
  localparam int X_W      = 8;
  localparam int Y_W      = 7;
  localparam int PAGE_W   = 3;
  localparam int CHUNK_W  = 3;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PIXEL   = 3'd0,
    CMD_CLEAR_PIXEL = 3'd1,
    CMD_FILL_ALL    = 3'd2,
    CMD_CLEAR_ALL   = 3'd3,
    CMD_READ_CHUNK  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_WALK,
    ST_IDLE,
    ST_PIX_WR,
    ST_CHUNK
  } state_t;

endpackage

/* hw/rtl/mpf_if.sv */
// Valid/ready channel interfaces for commands and chunk bytes.
interface mpf_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [mpf_pkg::CMD_W-1:0]     command;
  logic [mpf_pkg::X_W-1:0]       x;
  logic [mpf_pkg::Y_W-1:0]       y;
  logic [mpf_pkg::PAGE_W-1:0]    page;
  logic [mpf_pkg::CHUNK_W-1:0]   chunk;

  modport source (output valid, command, x, y, page, chunk, input ready);
  modport sink   (input valid, command, x, y, page, chunk, output ready);
endinterface

interface mpf_byte_if;
  logic                          valid;
  logic                          ready;
  logic [mpf_pkg::BYTE_W-1:0]    pixel_byte;
  logic                          last;

  modport source (output valid, pixel_byte, last, input ready);
  modport sink   (input valid, pixel_byte, last, output ready);
endinterface

/* hw/rtl/mpf_frame_ram.sv */
// Simple dual-port frame store: one write port, one registered read port.
module mpf_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mono_page_framebuffer_core.sv */
// Monochrome page-organized framebuffer: command decode, walk and chunk readout.
//
// Holds a 128x64 one-bit image as 8 pages of 128 column bytes in a single
// synchronous RAM. After reset the block sweeps the RAM to zero, one byte a
// cycle, with cmd.ready low. Set and clear pixel read the byte, then write
// back the modified byte; off-screen pixels and unused codes stay idle. Fill
// and clear all sweep the RAM with ones or zeros. Read chunk returns 16 bytes,
// each read from the RAM into the single output register; a read waits until
// the previous byte has landed and the output register is free, and the last
// byte is flagged. The final byte of a chunk can sit in the output register
// while the next command is taken. One command is worked on at a time.
module mono_page_framebuffer_core (
  input  logic         clk,
  input  logic         rst,
  mpf_cmd_if.sink      cmd,
  mpf_byte_if.source   result
);

  localparam int AW = mpf_pkg::ADDR_W;
  localparam int BW = mpf_pkg::BYTE_W;

  mpf_pkg::state_t state, state_next;

  logic [AW-1:0]                  walk_index;
  logic [BW-1:0]                  walk_value;
  logic [AW-1:0]                  pix_addr;
  logic [BW-1:0]                  pix_mask;
  logic                           pix_set;
  logic [mpf_pkg::PAGE_W-1:0]     rd_page;
  logic [mpf_pkg::CHUNK_W-1:0]    rd_chunk;
  logic [mpf_pkg::CNT_W-1:0]      byte_count;
  logic                           rd_pend;
  logic                           rd_zero;
  logic                           rd_last;
  logic                           out_valid;
  logic [BW-1:0]                  out_byte;
  logic                           out_last;

  logic                           accept;
  logic                           on_screen;
  logic [AW-1:0]                  in_pix_addr;
  logic [BW-1:0]                  in_mask;
  logic [mpf_pkg::COLX_W-1:0]     chunk_col;
  logic                           chunk_in_range;
  logic [AW-1:0]                  chunk_addr;
  logic                           issue;
  logic                           walk_done;
  logic                           byte_last;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [BW-1:0]                  ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [BW-1:0]                  ram_rdata;

  mpf_frame_ram #(
    .DEPTH (mpf_pkg::FRAME_BYTES),
    .WIDTH (BW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd.ready         = (state == mpf_pkg::ST_IDLE);
  assign accept            = cmd.valid && cmd.ready;
  assign result.valid      = out_valid;
  assign result.pixel_byte = out_byte;
  assign result.last       = out_last;

  assign on_screen   = (int'(cmd.x) < mpf_pkg::COLUMNS) && (int'(cmd.y) < mpf_pkg::ROWS);
  assign in_pix_addr = AW'(int'(cmd.y[mpf_pkg::Y_W-1:3]) * mpf_pkg::COLUMNS + int'(cmd.x));
  assign in_mask     = BW'(1) << cmd.y[2:0];

  assign chunk_col = mpf_pkg::COLX_W'(rd_chunk) * mpf_pkg::COLX_W'(mpf_pkg::CHUNK_BYTES)
                   + mpf_pkg::COLX_W'(byte_count);
  assign chunk_in_range = (int'(chunk_col) < mpf_pkg::COLUMNS)
                       && (int'(rd_page) < mpf_pkg::PAGES);
  assign chunk_addr = AW'(int'(rd_page) * mpf_pkg::COLUMNS + int'(chunk_col));

  assign walk_done = (walk_index == AW'(mpf_pkg::FRAME_BYTES - 1));
  assign byte_last = (byte_count == mpf_pkg::CNT_W'(mpf_pkg::CHUNK_BYTES - 1));

  // Start a chunk byte only when the output register is free at the end of this cycle.
  assign issue = (state == mpf_pkg::ST_CHUNK) && !rd_pend && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpf_pkg::ST_WALK;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = walk_index;
    ram_wdata  = walk_value;
    ram_re     = 1'b0;
    ram_raddr  = in_pix_addr;
    unique case (state)
      mpf_pkg::ST_WALK: begin
        ram_we = 1'b1;
        if (walk_done) begin
          state_next = mpf_pkg::ST_IDLE;
        end
      end
      mpf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd.command)
            mpf_pkg::CMD_SET_PIXEL, mpf_pkg::CMD_CLEAR_PIXEL: begin
              if (on_screen) begin
                ram_re     = 1'b1;
                state_next = mpf_pkg::ST_PIX_WR;
              end
            end
            mpf_pkg::CMD_FILL_ALL, mpf_pkg::CMD_CLEAR_ALL: begin
              state_next = mpf_pkg::ST_WALK;
            end
            mpf_pkg::CMD_READ_CHUNK: begin
              state_next = mpf_pkg::ST_CHUNK;
            end
            default: begin
              state_next = mpf_pkg::ST_IDLE;
            end
          endcase
        end
      end
      mpf_pkg::ST_PIX_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = pix_addr;
        ram_wdata  = pix_set ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
        state_next = mpf_pkg::ST_IDLE;
      end
      mpf_pkg::ST_CHUNK: begin
        ram_raddr = chunk_addr;
        ram_re    = issue && chunk_in_range;
        if (rd_pend && rd_last) begin
          state_next = mpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_index <= '0;
      walk_value <= mpf_pkg::BYTE_ZEROS;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      byte_count <= '0;
    end else begin
      if (state == mpf_pkg::ST_WALK) begin
        walk_index <= walk_done ? '0 : walk_index + AW'(1);
      end
      if (accept) begin
        walk_value <= (cmd.command == mpf_pkg::CMD_FILL_ALL) ? mpf_pkg::BYTE_ONES
                                                              : mpf_pkg::BYTE_ZEROS;
        byte_count <= '0;
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        rd_pend    <= 1'b1;
        byte_count <= byte_count + mpf_pkg::CNT_W'(1);
      end
      // Read data lands in the cycle after issue; the output register is empty here.
      if (rd_pend) begin
        rd_pend   <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr <= in_pix_addr;
      pix_mask <= in_mask;
      pix_set  <= (cmd.command == mpf_pkg::CMD_SET_PIXEL);
      rd_page  <= cmd.page;
      rd_chunk <= cmd.chunk;
    end
    if (issue) begin
      rd_zero <= !chunk_in_range;
      rd_last <= byte_last;
    end
    if (rd_pend) begin
      out_byte <= rd_zero ? mpf_pkg::BYTE_ZEROS : ram_rdata;
      out_last <= rd_last;
    end
  end

  a_pend_in_chunk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == mpf_pkg::ST_CHUNK))
    else $error("read pending outside chunk readout");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("chunk byte would overwrite a held result");

  a_pix_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == mpf_pkg::ST_PIX_WR) |=> (state == mpf_pkg::ST_IDLE))
    else $error("pixel write back did not return to idle");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == mpf_pkg::ST_WALK) && walk_done |=>
      (state == mpf_pkg::ST_IDLE) && (walk_index == '0))
    else $error("walk did not end cleanly");

endmodule
